/* sv/state_space_model_observer_macros.svh */
// assertion macros for the state space model observer checker
`ifndef STATE_SPACE_MODEL_OBSERVER_MACROS_SVH
`define STATE_SPACE_MODEL_OBSERVER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SSMO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssmo same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define SSMO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssmo next-cycle check failed");

`endif

/* sv/ssmo_pkg.sv */
// shared types, codes and rounding helpers for the state space model observer
package ssmo_pkg;

  localparam int IDX_W   = 4;
  localparam int COEF_W  = 18;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = COEF_W + DATA_W;
  localparam int ACC_W   = 56;

  localparam logic [2:0] CMD_LOAD_COEF  = 3'd0;
  localparam logic [2:0] CMD_LOAD_INPUT = 3'd1;
  localparam logic [2:0] CMD_SET_PLANT  = 3'd2;
  localparam logic [2:0] CMD_SET_OBS    = 3'd3;
  localparam logic [2:0] CMD_PLANT_STEP = 3'd4;
  localparam logic [2:0] CMD_OBS_STEP   = 3'd5;
  localparam logic [2:0] CMD_READ       = 3'd6;
  localparam logic [2:0] CMD_PREPARE    = 3'd7;

  localparam logic [1:0] BANK_A = 2'd0;
  localparam logic [1:0] BANK_B = 2'd1;
  localparam logic [1:0] BANK_C = 2'd2;
  localparam logic [1:0] BANK_L = 2'd3;

  localparam logic [1:0] KIND_PLANT = 2'd0;
  localparam logic [1:0] KIND_OBS   = 2'd1;
  localparam logic [1:0] KIND_OUT   = 2'd2;
  localparam logic [1:0] KIND_PREV  = 2'd3;

  typedef enum logic [2:0] {
    CS_A, CS_B, CS_C, CS_F, CS_L
  } coef_sel_t;

  typedef struct packed {
    logic             mul_en;
    coef_sel_t        csel;
    logic [IDX_W-1:0] j;
    logic             add_en;
    logic             prep_wr;
    logic [IDX_W-1:0] jd;
    logic             clr;
    logic             commit_y;
    logic             commit_x;
    logic             commit_xh;
    logic             rot_x;
    logic             rot_xh;
  } cell_ctl_t;

  typedef struct packed {
    logic                     a;
    logic                     b;
    logic                     c;
    logic                     l;
    logic                     x;
    logic                     xh;
    logic [IDX_W-1:0]         col;
    logic signed [COEF_W-1:0] cval;
    logic signed [DATA_W-1:0] dval;
  } cell_wr_t;

  // round Q25.30 to Q15.16 and saturate
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + ACC_W'(8192)) >>> 14;
    if (r > ACC_W'(64'sd2147483647)) return 32'sh7fffffff;
    else if (r < -ACC_W'(64'sd2147483648)) return 32'sh80000000;
    else return r[DATA_W-1:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [PROD_W:0] a);
    if (a > (PROD_W+1)'(131071)) return 18'sh1ffff;
    else if (a < -(PROD_W+1)'(131072)) return 18'sh20000;
    else return a[COEF_W-1:0];
  endfunction

endpackage

/* sv/ssmo_cell.sv */
// one row cell: coefficient rows, state elements and a multiply-accumulate
module ssmo_cell #(
  parameter int NX = 4,
  parameter int NU = 2,
  parameter int AW = 2,
  parameter int BW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ssmo_pkg::cell_ctl_t                   ctl,
  input  ssmo_pkg::cell_wr_t                    wr,
  input  logic signed [ssmo_pkg::DATA_W-1:0]    data,
  input  logic signed [ssmo_pkg::DATA_W-1:0]    xin,
  input  logic signed [ssmo_pkg::DATA_W-1:0]    xhin,
  output logic signed [ssmo_pkg::DATA_W-1:0]    x,
  output logic signed [ssmo_pkg::DATA_W-1:0]    xh,
  output logic signed [ssmo_pkg::DATA_W-1:0]    y,
  output logic signed [ssmo_pkg::DATA_W-1:0]    yp,
  output logic signed [ssmo_pkg::COEF_W-1:0]    c_rd
);

  logic signed [ssmo_pkg::COEF_W-1:0] a_row [NX];
  logic signed [ssmo_pkg::COEF_W-1:0] b_row [NU];
  logic signed [ssmo_pkg::COEF_W-1:0] c_row [NX];
  logic signed [ssmo_pkg::COEF_W-1:0] f_row [NX];
  logic signed [ssmo_pkg::COEF_W-1:0] l_coef;
  logic signed [ssmo_pkg::COEF_W-1:0] coef;
  logic signed [ssmo_pkg::PROD_W-1:0] prod;
  logic signed [ssmo_pkg::ACC_W-1:0]  acc;
  logic signed [ssmo_pkg::PROD_W-1:0] lc;
  logic signed [ssmo_pkg::PROD_W:0]   fdiff;

  always_comb begin
    case (ctl.csel)
      ssmo_pkg::CS_A: coef = a_row[ctl.j[AW-1:0]];
      ssmo_pkg::CS_B: coef = b_row[ctl.j[BW-1:0]];
      ssmo_pkg::CS_C: coef = c_row[ctl.j[AW-1:0]];
      ssmo_pkg::CS_F: coef = f_row[ctl.j[AW-1:0]];
      ssmo_pkg::CS_L: coef = l_coef;
      default:        coef = '0;
    endcase
  end

  assign c_rd  = c_row[ctl.j[AW-1:0]];
  // prepare: A - round(L*C0) back to Q3.14
  assign lc    = (prod + ssmo_pkg::PROD_W'(8192)) >>> 14;
  assign fdiff = (ssmo_pkg::PROD_W+1)'(a_row[ctl.jd[AW-1:0]])
               - (ssmo_pkg::PROD_W+1)'(lc);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) prod <= coef * data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NX; k++) begin
        a_row[k] <= '0;
        c_row[k] <= '0;
        f_row[k] <= '0;
      end
      for (int k = 0; k < NU; k++) b_row[k] <= '0;
      l_coef <= '0;
      acc    <= '0;
      x      <= '0;
      xh     <= '0;
      y      <= '0;
      yp     <= '0;
    end else begin
      if (wr.a) a_row[wr.col[AW-1:0]] <= wr.cval;
      if (wr.b) b_row[wr.col[BW-1:0]] <= wr.cval;
      if (wr.c) c_row[wr.col[AW-1:0]] <= wr.cval;
      if (wr.l) l_coef <= wr.cval;
      if (ctl.prep_wr) f_row[ctl.jd[AW-1:0]] <= ssmo_pkg::sat_coef(fdiff);

      if (ctl.clr) acc <= '0;
      else if (ctl.add_en) acc <= acc + ssmo_pkg::ACC_W'(prod);

      if (ctl.commit_y) begin
        yp <= y;
        y  <= ssmo_pkg::sat_data(acc);
      end

      if (wr.x) x <= wr.dval;
      else if (ctl.commit_x) x <= ssmo_pkg::sat_data(acc);
      else if (ctl.rot_x) x <= xin;

      if (wr.xh) xh <= wr.dval;
      else if (ctl.commit_xh) xh <= ssmo_pkg::sat_data(acc);
      else if (ctl.rot_xh) xh <= xhin;
    end
  end

endmodule

/* sv/state_space_model_observer.sv */
// loads and sets finish with their transaction; a read result is registered out of the emit state
// plant step: C, A and B passes, then NY outputs and NX states, one per cycle while m_tready holds
// observer step: L, F and B passes, then NX observer states, one per cycle while m_tready holds
// prepare: one pass over the NX columns fills F; one command at a time, s_tready only in idle
// each cell owns one multiplier, state vectors rotate through the ring per column
// reset (rst, synchronous): all tables, states and outputs clear to zero, idle
module state_space_model_observer #(
  parameter int NX = 4,
  parameter int NU = 2,
  parameter int NY = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // row[3:0], col[7:4], value[39:8], sensor[71:40]
  input  logic [4:0]  s_tuser,   // command[2:0], bank[4:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // index[3:0], result_value[35:4], zero fill
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);

  localparam int NC = (NX > NY) ? NX : NY;
  localparam int AW = (NX > 1) ? $clog2(NX) : 1;
  localparam int BW = (NU > 1) ? $clog2(NU) : 1;
  localparam int IW = ssmo_pkg::IDX_W;
  localparam int DW = ssmo_pkg::DATA_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  typedef enum logic [5:0] {
    PH_Y = 6'b000001,
    PH_A = 6'b000010,
    PH_B = 6'b000100,
    PH_L = 6'b001000,
    PH_F = 6'b010000,
    PH_P = 6'b100000
  } phase_t;

  state_t st;
  phase_t ph;
  logic          plant;
  logic [IW-1:0] j;
  logic          add_q;
  logic          prep_q;
  logic [IW-1:0] jd_q;
  logic signed [DW-1:0] sensor_q;
  logic signed [DW-1:0] u [NU];
  logic [1:0]    ekind;
  logic [IW-1:0] eidx;
  logic          eread;

  logic [2:0]    in_cmd;
  logic [1:0]    in_bank;
  logic [IW-1:0] in_row;
  logic [IW-1:0] in_col;
  logic signed [DW-1:0] in_value;
  logic signed [DW-1:0] in_sensor;
  logic          accept;
  logic          j_last;
  logic signed [DW:0]  cround;
  logic signed [ssmo_pkg::PROD_W:0] cwide;
  logic signed [DW-1:0] dbus;
  logic signed [DW-1:0] emit_val;
  logic          emit_last;
  logic          emit_go;

  ssmo_pkg::cell_ctl_t ctl;
  ssmo_pkg::cell_wr_t  wr_base;
  ssmo_pkg::cell_wr_t  wr [NC];

  logic signed [DW-1:0] x_bus  [NC];
  logic signed [DW-1:0] xh_bus [NC];
  logic signed [DW-1:0] y_bus  [NC];
  logic signed [DW-1:0] yp_bus [NC];
  logic signed [ssmo_pkg::COEF_W-1:0] c_bus [NC];

  assign in_cmd    = s_tuser[2:0];
  assign in_bank   = s_tuser[4:3];
  assign in_row    = s_tdata[3:0];
  assign in_col    = s_tdata[7:4];
  assign in_value  = s_tdata[39:8];
  assign in_sensor = s_tdata[71:40];

  assign s_tready = (st == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Q15.16 value to Q3.14 coefficient: round off two bits, then saturate
  assign cround = ($signed({in_value[DW-1], in_value}) + 33'sd2) >>> 2;
  assign cwide  = (ssmo_pkg::PROD_W+1)'(cround);

  always_comb begin
    wr_base      = '0;
    wr_base.col  = in_col;
    wr_base.cval = ssmo_pkg::sat_coef(cwide);
    wr_base.dval = in_value;
    if (accept && in_cmd == ssmo_pkg::CMD_LOAD_COEF) begin
      unique case (in_bank)
        ssmo_pkg::BANK_A: wr_base.a = (5'(in_row) < 5'(NX)) && (5'(in_col) < 5'(NX));
        ssmo_pkg::BANK_B: wr_base.b = (5'(in_row) < 5'(NX)) && (5'(in_col) < 5'(NU));
        ssmo_pkg::BANK_C: wr_base.c = (5'(in_row) < 5'(NY)) && (5'(in_col) < 5'(NX));
        ssmo_pkg::BANK_L: wr_base.l = (5'(in_row) < 5'(NX)) && (in_col == '0);
        default: ;
      endcase
    end
    wr_base.x  = accept && in_cmd == ssmo_pkg::CMD_SET_PLANT && (5'(in_row) < 5'(NX));
    wr_base.xh = accept && in_cmd == ssmo_pkg::CMD_SET_OBS && (5'(in_row) < 5'(NX));
  end

  always_comb begin
    unique case (ph)
      PH_B:    j_last = (j == IW'(NU - 1));
      PH_L:    j_last = 1'b1;
      default: j_last = (j == IW'(NX - 1));
    endcase
  end

  // per-cycle control shared by every cell
  always_comb begin
    ctl           = '0;
    ctl.j         = j;
    ctl.jd        = jd_q;
    ctl.mul_en    = (st == ST_RUN);
    ctl.add_en    = add_q && !prep_q;
    ctl.prep_wr   = add_q && prep_q;
    ctl.clr       = (st == ST_COMMIT) ||
                    (accept && (in_cmd == ssmo_pkg::CMD_PLANT_STEP ||
                                in_cmd == ssmo_pkg::CMD_OBS_STEP));
    ctl.commit_y  = (st == ST_COMMIT) && (ph == PH_Y);
    ctl.commit_x  = (st == ST_COMMIT) && (ph == PH_B) && plant;
    ctl.commit_xh = (st == ST_COMMIT) && (ph == PH_B) && !plant;
    ctl.rot_x     = (st == ST_RUN) && (ph == PH_Y || ph == PH_A);
    ctl.rot_xh    = (st == ST_RUN) && (ph == PH_F);
    unique case (ph)
      PH_Y:    ctl.csel = ssmo_pkg::CS_C;
      PH_A:    ctl.csel = ssmo_pkg::CS_A;
      PH_B:    ctl.csel = ssmo_pkg::CS_B;
      PH_F:    ctl.csel = ssmo_pkg::CS_F;
      default: ctl.csel = ssmo_pkg::CS_L;
    endcase
  end

  always_comb begin
    unique case (ph)
      PH_Y, PH_A: dbus = x_bus[0];
      PH_B:       dbus = u[j[BW-1:0]];
      PH_L:       dbus = sensor_q;
      PH_F:       dbus = xh_bus[0];
      default:    dbus = DW'(c_bus[0]);
    endcase
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    logic signed [DW-1:0] xin;
    logic signed [DW-1:0] xhin;

    always_comb begin
      wr[k]      = wr_base;
      wr[k].a    = wr_base.a  && (in_row == IW'(k));
      wr[k].b    = wr_base.b  && (in_row == IW'(k));
      wr[k].c    = wr_base.c  && (in_row == IW'(k));
      wr[k].l    = wr_base.l  && (in_row == IW'(k));
      wr[k].x    = wr_base.x  && (in_row == IW'(k));
      wr[k].xh   = wr_base.xh && (in_row == IW'(k));
    end

    // ring over the first NX cells, cell zero shows the current column
    if (k < NX - 1) begin : g_mid
      assign xin  = x_bus[k+1];
      assign xhin = xh_bus[k+1];
    end else begin : g_wrap
      assign xin  = x_bus[0];
      assign xhin = xh_bus[0];
    end

    ssmo_cell #(.NX(NX), .NU(NU), .AW(AW), .BW(BW)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .wr   (wr[k]),
      .data (dbus),
      .xin  (xin),
      .xhin (xhin),
      .x    (x_bus[k]),
      .xh   (xh_bus[k]),
      .y    (y_bus[k]),
      .yp   (yp_bus[k]),
      .c_rd (c_bus[k])
    );
  end

  always_comb begin
    emit_val = '0;
    for (int k = 0; k < NC; k++) begin
      if (eidx == IW'(k)) begin
        case (ekind)
          ssmo_pkg::KIND_PLANT: if (k < NX) emit_val = x_bus[k];
          ssmo_pkg::KIND_OBS:   if (k < NX) emit_val = xh_bus[k];
          ssmo_pkg::KIND_OUT:   if (k < NY) emit_val = y_bus[k];
          default:              if (k < NY) emit_val = yp_bus[k];
        endcase
      end
    end
  end

  assign emit_last = eread ||
                     ((ekind == ssmo_pkg::KIND_PLANT || ekind == ssmo_pkg::KIND_OBS) &&
                      eidx == IW'(NX - 1));
  assign emit_go   = (st == ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    add_q  <= (st == ST_RUN);
    prep_q <= (st == ST_RUN) && (ph == PH_P);
    jd_q   <= j;
    if (accept && in_cmd == ssmo_pkg::CMD_OBS_STEP) sensor_q <= in_sensor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NU; k++) u[k] <= '0;
    end else if (accept && in_cmd == ssmo_pkg::CMD_LOAD_INPUT && 5'(in_row) < 5'(NU)) begin
      u[in_row[BW-1:0]] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      ph       <= PH_Y;
      plant    <= 1'b0;
      j        <= '0;
      ekind    <= '0;
      eidx     <= '0;
      eread    <= 1'b0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            j <= '0;
            unique case (in_cmd)
              ssmo_pkg::CMD_PLANT_STEP: begin
                plant <= 1'b1;
                ph    <= PH_Y;
                st    <= ST_RUN;
              end
              ssmo_pkg::CMD_OBS_STEP: begin
                plant <= 1'b0;
                ph    <= PH_L;
                st    <= ST_RUN;
              end
              ssmo_pkg::CMD_PREPARE: begin
                ph <= PH_P;
                st <= ST_RUN;
              end
              ssmo_pkg::CMD_READ: begin
                ekind <= in_bank;
                eidx  <= in_row;
                eread <= 1'b1;
                st    <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (j_last) begin
            j <= '0;
            unique case (ph)
              PH_A:    ph <= PH_B;
              PH_L:    ph <= PH_F;
              PH_F:    ph <= PH_B;
              default: st <= ST_WAIT;
            endcase
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_WAIT: begin
          st <= (ph == PH_P) ? ST_IDLE : ST_COMMIT;
        end
        ST_COMMIT: begin
          if (ph == PH_Y) begin
            ph <= PH_A;
            st <= ST_RUN;
          end else begin
            ekind <= plant ? ssmo_pkg::KIND_OUT : ssmo_pkg::KIND_OBS;
            eidx  <= '0;
            eread <= 1'b0;
            st    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (emit_last) begin
              st <= ST_IDLE;
            end else if (ekind == ssmo_pkg::KIND_OUT && eidx == IW'(NY - 1)) begin
              ekind <= ssmo_pkg::KIND_PLANT;
              eidx  <= '0;
            end else begin
              eidx <= eidx + 1'b1;
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tuser <= ekind;
      m_tdata <= {4'b0000, emit_val, eidx};
      m_tlast <= emit_last;
    end
  end

endmodule

/* sv/ssmo_checker.sv */
// port-level checks for the state space model observer, bound to the top level
`include "state_space_model_observer_macros.svh"

module ssmo_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [4:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result holds its payload
  `SSMO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // loads and sets leave the block ready for the next command
  `SSMO_ASSERT_NEXT(a_silent_ready, s_tvalid && s_tready && !s_tuser[2], s_tready)

  // steps, reads and prepare leave the block busy after their transaction
  `SSMO_ASSERT_NEXT(a_busy_after_work, s_tvalid && s_tready && s_tuser[2], !s_tready)

endmodule

bind state_space_model_observer ssmo_checker u_ssmo_checker (.*);
